[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// These macros hold the shared assertion forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Checks that a consequence holds whenever its antecedent holds.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/ics_pkg.sv]
// ---------------------------------------------------------------------------
// Interval coverage set package
// Operation codes, sequencer states and the result record.
// ---------------------------------------------------------------------------
package ics_pkg;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_CONTAINS  = 2'd1,
        OP_NEXT_FREE = 2'd2,
        OP_RESERVED  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO_RD,
        ST_LO_EV,
        ST_HI_RD,
        ST_HI_EV,
        ST_GAP_RD,
        ST_GAP_EV,
        ST_FIN,
        ST_OUT,
        ST_MV_RD,
        ST_MV_EV,
        ST_WR,
        ST_Q_RD,
        ST_Q_EV
    } state_t;

    typedef struct packed {
        logic [31:0] gap_start;
        logic [31:0] gap_end;
        logic        gap_valid;
        logic        is_last;
        logic        found;
        logic [31:0] free_position;
        logic        overflow;
    } res_t;

endpackage

[design/interval_coverage_set.sv]
// ---------------------------------------------------------------------------
// Interval coverage set
// Sorted table of disjoint intervals with insert-and-merge and two queries.
// ---------------------------------------------------------------------------
// A query scans the stored intervals in order until a match or the end.
// An insert finds the entries it touches, reports each gap through a result
// handshake, moves later entries and writes the merged interval; one item is
// in work at a time, set by the single table read port. Reset is asynchronous
// and empties the table at once.
module interval_coverage_set #(
    parameter int MAX_INTERVALS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] gap_start,
    output logic [31:0] gap_end,
    output logic        gap_valid,
    output logic        is_last,
    output logic        found,
    output logic [31:0] free_position,
    output logic        overflow
);
    import ics_pkg::*;

    localparam int IW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    logic [31:0] starts_mem [MAX_INTERVALS];
    logic [31:0] ends_mem [MAX_INTERVALS];
    logic [31:0] rd_s_reg, rd_e_reg;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [31:0] wr_s, wr_e;
    logic wr_en;

    state_t state_reg, state_next;
    op_t op_reg, op_next;
    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic [31:0] s_lo_reg, s_lo_next, fin_reg, fin_next, cur_reg, cur_next;
    logic [CW-1:0] cnt_reg, cnt_next, idx_reg, idx_next, lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next, src_reg, src_next, dst_reg, dst_next;
    logic up_reg, up_next, commit_reg, commit_next;
    res_t res_reg, res_next;
    logic end_hi;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            starts_mem[wr_addr] <= wr_s;
            ends_mem[wr_addr] <= wr_e;
        end
        rd_s_reg <= starts_mem[rd_addr];
        rd_e_reg <= ends_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg <= a_next;
        b_reg <= b_next;
        s_lo_reg <= s_lo_next;
        fin_reg <= fin_next;
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        up_reg <= up_next;
        commit_reg <= commit_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        a_next = a_reg;
        b_next = b_reg;
        s_lo_next = s_lo_reg;
        fin_next = fin_reg;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        up_next = up_reg;
        commit_next = commit_reg;
        res_next = res_reg;
        rd_addr = idx_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = lo_reg[IW-1:0];
        wr_s = a_reg;
        wr_e = b_reg;
        end_hi = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op_t'(operation);
                    a_next = range_start;
                    b_next = range_end;
                    idx_next = '0;
                    commit_next = 1'b0;
                    res_next = '0;
                    res_next.is_last = 1'b1;
                    if (op_t'(operation) == OP_INSERT)
                    begin
                        if (range_end <= range_start)
                            state_next = ST_OUT;
                        else
                            state_next = ST_LO_RD;
                    end
                    else if (op_t'(operation) == OP_CONTAINS
                             || op_t'(operation) == OP_NEXT_FREE)
                    begin
                        if (op_t'(operation) == OP_NEXT_FREE)
                            res_next.free_position = range_start;
                        state_next = ST_Q_RD;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_LO_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    lo_next = idx_reg;
                    fin_next = a_reg;
                    state_next = ST_HI_RD;
                end
                else
                    state_next = ST_LO_EV;
            end
            ST_LO_EV:
            begin
                if (rd_e_reg < a_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_LO_RD;
                end
                else
                begin
                    lo_next = idx_reg;
                    fin_next = a_reg;
                    state_next = ST_HI_RD;
                end
            end
            ST_HI_RD:
            begin
                if (idx_reg == cnt_reg)
                    end_hi = 1'b1;
                else
                    state_next = ST_HI_EV;
            end
            ST_HI_EV:
            begin
                if (rd_s_reg <= b_reg)
                begin
                    if (idx_reg == lo_reg)
                        s_lo_next = rd_s_reg;
                    if (rd_e_reg > a_reg)
                        fin_next = rd_e_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_HI_RD;
                end
                else
                    end_hi = 1'b1;
            end
            ST_GAP_RD:
            begin
                if (idx_reg == hi_reg)
                    state_next = ST_FIN;
                else
                    state_next = ST_GAP_EV;
            end
            ST_GAP_EV:
            begin
                idx_next = idx_reg + 1'b1;
                if (rd_e_reg > cur_reg)
                    cur_next = rd_e_reg;
                if (rd_s_reg > cur_reg)
                begin
                    res_next = '0;
                    res_next.gap_start = cur_reg;
                    res_next.gap_end = rd_s_reg;
                    res_next.gap_valid = 1'b1;
                    res_next.is_last = (idx_reg + 1'b1 == hi_reg) && (fin_reg >= b_reg);
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_GAP_RD;
            end
            ST_FIN:
            begin
                res_next = '0;
                res_next.is_last = 1'b1;
                if (fin_reg < b_reg)
                begin
                    res_next.gap_start = fin_reg;
                    res_next.gap_end = b_reg;
                    res_next.gap_valid = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (!res_reg.is_last)
                        state_next = ST_GAP_RD;
                    else if (!commit_reg)
                        state_next = ST_IDLE;
                    else if (hi_reg - lo_reg == CW'(1))
                        state_next = ST_WR;
                    else
                    begin
                        up_next = (hi_reg == lo_reg);
                        if (hi_reg == lo_reg)
                        begin
                            src_next = cnt_reg - 1'b1;
                            dst_next = cnt_reg;
                        end
                        else
                        begin
                            src_next = hi_reg;
                            dst_next = lo_reg + 1'b1;
                        end
                        state_next = ST_MV_RD;
                    end
                end
            end
            ST_MV_RD:
            begin
                rd_addr = src_reg[IW-1:0];
                if (up_reg ? (dst_reg == lo_reg) : (src_reg == cnt_reg))
                    state_next = ST_WR;
                else
                    state_next = ST_MV_EV;
            end
            ST_MV_EV:
            begin
                wr_en = 1'b1;
                wr_addr = dst_reg[IW-1:0];
                wr_s = rd_s_reg;
                wr_e = rd_e_reg;
                src_next = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                dst_next = up_reg ? dst_reg - 1'b1 : dst_reg + 1'b1;
                state_next = ST_MV_RD;
            end
            ST_WR:
            begin
                wr_en = 1'b1;
                wr_s = (hi_reg != lo_reg && s_lo_reg < a_reg) ? s_lo_reg : a_reg;
                wr_e = (fin_reg > b_reg) ? fin_reg : b_reg;
                cnt_next = cnt_reg - (hi_reg - lo_reg) + 1'b1;
                state_next = ST_IDLE;
            end
            ST_Q_RD:
            begin
                if (idx_reg == cnt_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_Q_EV;
            end
            ST_Q_EV:
            begin
                idx_next = idx_reg + 1'b1;
                state_next = ST_Q_RD;
                if (op_reg == OP_CONTAINS)
                begin
                    if (rd_s_reg <= a_reg && rd_e_reg >= b_reg)
                    begin
                        res_next.found = 1'b1;
                        state_next = ST_OUT;
                    end
                end
                else if (rd_s_reg <= a_reg && a_reg < rd_e_reg)
                begin
                    res_next.free_position = rd_e_reg;
                    state_next = ST_OUT;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (end_hi)
        begin
            hi_next = idx_reg;
            if (idx_reg == lo_reg && cnt_reg == CW'(MAX_INTERVALS))
            begin
                res_next = '0;
                res_next.overflow = 1'b1;
                res_next.is_last = 1'b1;
                state_next = ST_OUT;
            end
            else
            begin
                commit_next = 1'b1;
                idx_next = lo_reg;
                cur_next = a_reg;
                state_next = ST_GAP_RD;
            end
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign gap_start = res_reg.gap_start;
    assign gap_end = res_reg.gap_end;
    assign gap_valid = res_reg.gap_valid;
    assign is_last = res_reg.is_last;
    assign found = res_reg.found;
    assign free_position = res_reg.free_position;
    assign overflow = res_reg.overflow;

endmodule

[design/ics_checker.sv]
// ---------------------------------------------------------------------------
// Interval coverage set checker
// Port-level checks on the item handshakes and the result fields.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ics_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] gap_start,
    input logic [31:0] gap_end,
    input logic        gap_valid,
    input logic        is_last,
    input logic        overflow
);
    // A new item is never taken while a result is still pending.
    `ASSERT_ALWAYS(a_no_overlap, !(out_valid && in_ready))
    // A real gap is never empty.
    `ASSERT_IMPL(a_gap_nonempty, out_valid && gap_valid, gap_end > gap_start)
    // A refused insert is a single final result with no gap.
    `ASSERT_IMPL(a_overflow_alone, out_valid && overflow, is_last && !gap_valid)
    // A stalled result stays valid and keeps its gap start.
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(gap_start))

endmodule

bind interval_coverage_set ics_assertions u_ics_checker (.*);

[bench/ics_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Interval coverage set checker
// Watches both channels, keeps its own copy of the interval table, works out
// the results of every accepted item and compares them with the block's.
// ---------------------------------------------------------------------------
module ics_checker #(
    parameter int MAX_INTERVALS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] gap_start,
    input  logic [31:0] gap_end,
    input  logic        gap_valid,
    input  logic        is_last,
    input  logic        found,
    input  logic [31:0] free_position,
    input  logic        overflow,
    output int          errors,
    output int          pending
);
    import ics_pkg::*;

    logic [31:0] tab_lo [MAX_INTERVALS];
    logic [31:0] tab_hi [MAX_INTERVALS];
    int          tab_n;
    res_t        gap_queue [$];

    assign pending = gap_queue.size();

    function automatic res_t blank_res();
        res_t r;
        r = '0;
        return r;
    endfunction

    task automatic add_range(input logic [31:0] a, input logic [31:0] b);
        int   lo;
        int   hi;
        int   k;
        int   nn;
        int   nres;
        int   i;
        logic [31:0] cur;
        logic [31:0] ns;
        logic [31:0] ne;
        res_t r;
        logic [31:0] s2 [MAX_INTERVALS];
        logic [31:0] e2 [MAX_INTERVALS];
        if (b <= a)
        begin
            r = blank_res();
            r.is_last = 1'b1;
            gap_queue.push_back(r);
            return;
        end
        lo = 0;
        while (lo < tab_n && tab_hi[lo] < a)
            lo++;
        hi = lo;
        while (hi < tab_n && tab_lo[hi] <= b)
            hi++;
        k = hi - lo;
        nn = tab_n - k + 1;
        if (nn > MAX_INTERVALS)
        begin
            r = blank_res();
            r.overflow = 1'b1;
            r.is_last = 1'b1;
            gap_queue.push_back(r);
            return;
        end
        cur = a;
        nres = 0;
        for (i = lo; i < hi; i++)
        begin
            if (tab_lo[i] > cur)
            begin
                r = blank_res();
                r.gap_start = cur;
                r.gap_end = tab_lo[i];
                r.gap_valid = 1'b1;
                r.is_last = 1'b0;
                gap_queue.push_back(r);
                nres++;
            end
            if (tab_hi[i] > cur)
                cur = tab_hi[i];
        end
        if (cur < b)
        begin
            r = blank_res();
            r.gap_start = cur;
            r.gap_end = b;
            r.gap_valid = 1'b1;
            gap_queue.push_back(r);
            nres++;
        end
        if (nres == 0)
            gap_queue.push_back(blank_res());
        gap_queue[gap_queue.size() - 1].is_last = 1'b1;
        ns = a;
        ne = b;
        if (k > 0)
        begin
            if (tab_lo[lo] < ns)
                ns = tab_lo[lo];
            if (tab_hi[hi - 1] > ne)
                ne = tab_hi[hi - 1];
        end
        for (i = 0; i < lo; i++)
        begin
            s2[i] = tab_lo[i];
            e2[i] = tab_hi[i];
        end
        s2[lo] = ns;
        e2[lo] = ne;
        for (i = hi; i < tab_n; i++)
        begin
            s2[lo + 1 + i - hi] = tab_lo[i];
            e2[lo + 1 + i - hi] = tab_hi[i];
        end
        for (i = 0; i < nn; i++)
        begin
            tab_lo[i] = s2[i];
            tab_hi[i] = e2[i];
        end
        tab_n = nn;
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [31:0] a,
                                input logic [31:0] b);
        res_t r;
        int   i;
        if (op == OP_INSERT)
        begin
            add_range(a, b);
            return;
        end
        r = blank_res();
        r.is_last = 1'b1;
        if (op == OP_CONTAINS)
        begin
            for (i = 0; i < tab_n; i++)
                if (tab_lo[i] <= a && tab_hi[i] >= b)
                    r.found = 1'b1;
        end
        else if (op == OP_NEXT_FREE)
        begin
            r.free_position = a;
            for (i = 0; i < tab_n; i++)
                if (tab_lo[i] <= a && a < tab_hi[i])
                    r.free_position = tab_hi[i];
        end
        gap_queue.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            tab_n = 0;
            gap_queue.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{gap_start, gap_end, gap_valid, is_last, found,
                        free_position, overflow};
                if (gap_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = gap_queue.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch, expected %h, actual %h",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_item(operation, range_start, range_end);
        end
    end

endmodule

[bench/tb_interval_coverage_set.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Interval coverage set testbench
// Drives directed and random inserts and queries in bursts against a
// stalling receiver; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_interval_coverage_set;
    import ics_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] gap_start;
    logic [31:0] gap_end;
    logic        gap_valid;
    logic        is_last;
    logic        found;
    logic [31:0] free_position;
    logic        overflow;
    int          errors;
    int          pending;
    int          idle_cycles;

    interval_coverage_set i_dut (.*);
    ics_checker i_checker (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        int m;
        m = $urandom_range(0, 15);
        if ($time < 3000 || (($time / 4000) % 3) == 0)
            out_ready <= 1'b1;
        else
            out_ready <= (m > 5);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        operation <= op;
        range_start <= a;
        range_end <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic go_idle(input int cycles);
        in_valid <= 1'b0;
        operation <= 2'($urandom());
        range_start <= $urandom();
        range_end <= $urandom();
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain();
        go_idle(1);
        while (pending != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic random_item(input logic [31:0] span);
        logic [31:0] a;
        logic [31:0] b;
        int          sel;
        sel = $urandom_range(0, 99);
        a = $urandom_range(0, span);
        b = a + $urandom_range(1, span / 8 + 1);
        if (sel < 5)
        begin
            a = $urandom();
            b = $urandom();
        end
        else if (sel < 8)
            b = a - $urandom_range(0, 3);
        if (sel < 55)
            send_item(OP_INSERT, a, b);
        else if (sel < 75)
            send_item(OP_CONTAINS, a, b);
        else if (sel < 95)
            send_item(OP_NEXT_FREE, a, b);
        else
            send_item(OP_RESERVED, a, b);
    endtask

    initial
    begin
        int n;
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        range_start = '0;
        range_end = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(OP_NEXT_FREE, 32'd5, 32'd0);
        send_item(OP_CONTAINS, 32'd0, 32'd0);
        send_item(OP_INSERT, 32'd10, 32'd10);
        send_item(OP_INSERT, 32'd20, 32'd10);
        send_item(OP_INSERT, 32'd10, 32'd20);
        send_item(OP_INSERT, 32'd30, 32'd40);
        send_item(OP_INSERT, 32'd20, 32'd30);
        send_item(OP_INSERT, 32'd12, 32'd18);
        send_item(OP_CONTAINS, 32'd10, 32'd40);
        send_item(OP_CONTAINS, 32'd15, 32'd15);
        send_item(OP_CONTAINS, 32'd5, 32'd15);
        send_item(OP_NEXT_FREE, 32'd15, 32'd0);
        send_item(OP_NEXT_FREE, 32'd40, 32'd0);
        send_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_item(OP_NEXT_FREE, 32'hFFFF_FFFE, 32'd0);
        send_item(OP_CONTAINS, 32'd0, 32'hFFFF_FFFF);
        drain();

        for (n = 0; n < 18; n++)
            send_item(OP_INSERT, 32'h8000_0000 + n * 4, 32'h8000_0000 + n * 4 + 1);
        send_item(OP_INSERT, 32'h8000_0001, 32'h8000_0044);
        drain();

        n = 0;
        while (n < 330)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                random_item((n % 100 < 50) ? 32'd400 : 32'd100000);
                n++;
            end
            if (n % 110 < 12)
                drain();
            else if ($urandom_range(0, 3) != 0)
                go_idle($urandom_range(1, 30));
        end
        drain();
        repeat (50) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
